/* rtl/c_subset_token_scanner_top_macros.svh */
// assertion helpers used by the scanner core
`ifndef C_SUBSET_TOKEN_SCANNER_TOP_MACROS_SVH
`define C_SUBSET_TOKEN_SCANNER_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define CSTOK_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cstok same-cycle check failed");

// next-cycle implication, disabled during reset
`define CSTOK_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cstok next-cycle check failed");

`endif

/* rtl/cstok_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cstok_pkg
// types, constants and character-class helpers for the token scanner
// ----------------------------------------------------------------------------
package cstok_pkg;

  localparam int unsigned POSITION_BITS_DEFAULT = 16;

  // result queue geometry
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_BITS   = 2;
  localparam int unsigned QCNT_BITS   = 3;

  typedef enum logic [2:0] {
    MODE_IDLE      = 3'd0,
    MODE_NUMBER    = 3'd1,
    MODE_IDENT     = 3'd2,
    MODE_LIT_OPEN  = 3'd3,
    MODE_LIT_ESC   = 3'd4,
    MODE_LIT_CLOSE = 3'd5
  } scan_mode_t;

  typedef logic [4:0] kind_t;

  localparam kind_t KIND_EOF     = 5'd0;
  localparam kind_t KIND_LPAREN  = 5'd1;
  localparam kind_t KIND_RPAREN  = 5'd2;
  localparam kind_t KIND_LBRACE  = 5'd3;
  localparam kind_t KIND_RBRACE  = 5'd4;
  localparam kind_t KIND_LBRACK  = 5'd5;
  localparam kind_t KIND_RBRACK  = 5'd6;
  localparam kind_t KIND_ASSIGN  = 5'd7;
  localparam kind_t KIND_PLUS    = 5'd8;
  localparam kind_t KIND_MINUS   = 5'd9;
  localparam kind_t KIND_SLASH   = 5'd10;
  localparam kind_t KIND_STAR    = 5'd11;
  localparam kind_t KIND_SEMI    = 5'd12;
  localparam kind_t KIND_CHARLIT = 5'd13;
  localparam kind_t KIND_NUMBER  = 5'd14;
  localparam kind_t KIND_IDENT   = 5'd15;
  localparam kind_t KIND_KW_CHAR = 5'd16;
  localparam kind_t KIND_UNREC   = 5'd20;
  localparam kind_t KIND_ERR_UNTERM = 5'd21;
  localparam kind_t KIND_ERR_ESCAPE = 5'd22;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_QUOTE = 8'h27;
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;

  // reserved words, zero padded to eight characters
  localparam logic [7:0] KW_TEXT [4][8] = '{
    '{"c", "h", "a", "r", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"v", "o", "i", "d", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"p", "r", "n", "t", "i", "n", "t", 8'h00}
  };
  localparam logic [2:0] KW_LEN [4] = '{3'd4, 3'd3, 3'd4, 3'd7};

  typedef struct packed {
    kind_t       token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [15:0] line_number;
    logic        last_of_run;
  } result_t;

  // up to two results per source byte, compacted into slot0 first
  typedef struct packed {
    logic    valid0;
    logic    valid1;
    result_t slot0;
    result_t slot1;
  } push_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z")) || (b == "_");
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_CR) || (b == CHAR_LF);
  endfunction

  function automatic kind_t punct_kind(input logic [7:0] b);
    kind_t k;
    unique case (b)
      "(":     k = KIND_LPAREN;
      ")":     k = KIND_RPAREN;
      "{":     k = KIND_LBRACE;
      "}":     k = KIND_RBRACE;
      "[":     k = KIND_LBRACK;
      "]":     k = KIND_RBRACK;
      "=":     k = KIND_ASSIGN;
      "+":     k = KIND_PLUS;
      "-":     k = KIND_MINUS;
      "/":     k = KIND_SLASH;
      "*":     k = KIND_STAR;
      ";":     k = KIND_SEMI;
      default: k = KIND_UNREC;
    endcase
    return k;
  endfunction

endpackage

/* rtl/cstok_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cstok_if
// valid/ready channels for source bytes and tokens
// ----------------------------------------------------------------------------
interface cstok_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;

  modport source (output valid, output source_byte, input ready);
  modport sink (input valid, input source_byte, output ready);
endinterface

interface cstok_token_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic [15:0] line_number;
  logic        last_of_run;

  modport source (
    output valid, output token_kind, output token_start, output token_length,
    output line_number, output last_of_run, input ready
  );
  modport sink (
    input valid, input token_kind, input token_start, input token_length,
    input line_number, input last_of_run, output ready
  );
endinterface

/* rtl/c_subset_token_scanner_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_subset_token_scanner_top
// streaming scanner for a small c-like language; unstalled, one byte a cycle
// ----------------------------------------------------------------------------
// usage
// - chars: one source byte per transaction; a zero byte ends the source
// - tokens: one token per transaction with kind, start offset, length and
//   line; last_of_run marks the final token caused by one source byte
// - a byte that ends a pending number, identifier or literal and is itself
//   a token gives two token transactions, otherwise one or none
// - a taken byte is scanned from the input register; its results go into
//   the result queue, which drives tokens one result per transaction
// - throughput: one byte per cycle while the queue has room
// - a four-entry result queue sits between scan logic and tokens, so bytes
//   keep flowing while a token waits; when tokens stalls the queue fills,
//   a byte then waits in the input register while fewer than two entries
//   are free, and chars.ready stays low until that byte moves on
// - reset (rst, synchronous) empties the queue and returns the scanner to
//   line one, offset zero, between tokens; the end-of-source token does
//   the same to the scanner state
// ----------------------------------------------------------------------------
module c_subset_token_scanner_top #(
  parameter int unsigned POSITION_BITS = cstok_pkg::POSITION_BITS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  cstok_byte_if.sink    chars,
  cstok_token_if.source tokens
);
  import cstok_pkg::*;

  // results of the current byte, and queue space for them
  push_t push;
  logic  room;

  // input register, scan state and result forming
  cstok_core #(
    .POSITION_BITS(POSITION_BITS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .chars(chars),
    .room (room),
    .push (push)
  );

  // result queue drives the token channel
  cstok_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .room  (room),
    .tokens(tokens)
  );

endmodule

/* rtl/cstok_core.sv */
`timescale 1ns / 1ps
`include "c_subset_token_scanner_top_macros.svh"
// ----------------------------------------------------------------------------
// cstok_core
// input register and single-pass scan logic, up to two results per byte
// ----------------------------------------------------------------------------
module cstok_core #(
  parameter int unsigned POSITION_BITS = cstok_pkg::POSITION_BITS_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  cstok_byte_if.sink      chars,
  input  logic            room,
  output cstok_pkg::push_t push
);
  import cstok_pkg::*;

  localparam int unsigned PB = POSITION_BITS;
  localparam logic [PB-1:0] POS_MAX = '1;

  logic          in_valid;
  logic [7:0]    in_byte;
  logic          advance;

  scan_mode_t    mode, mode_next;
  logic [PB-1:0] byte_position, byte_position_next;
  logic [PB-1:0] token_begin, token_begin_next;
  logic [15:0]   line_count, line_count_next;
  logic [3:0]    keyword_match, keyword_match_next;

  logic [PB-1:0] used;
  logic [PB:0]   used_inc;
  logic          at_max;
  logic [3:0]    match_cont;
  logic [3:0]    match_first;

  logic          consumed;
  logic          a_valid, b_valid;
  kind_t         a_kind, b_kind;
  logic [PB:0]   a_len;
  logic [15:0]   b_len;
  result_t       res_a, res_b;

  function automatic logic [3:0] kw_step(input logic [3:0] bits, input logic [PB-1:0] k,
                                         input logic [7:0] b);
    logic [3:0] res;
    res = '0;
    for (int i = 0; i < 4; i++) begin
      if (bits[i] && (k < PB'(KW_LEN[i])) && (KW_TEXT[i][k[2:0]] == b)) begin
        res[i] = 1'b1;
      end
    end
    return res;
  endfunction

  // lowest-numbered matching reserved word wins
  function automatic kind_t ident_kind(input logic [3:0] bits, input logic [PB-1:0] len);
    kind_t k;
    k = KIND_IDENT;
    for (int i = 3; i >= 0; i--) begin
      if (bits[i] && (len == PB'(KW_LEN[i]))) begin
        k = KIND_KW_CHAR + 5'(i);
      end
    end
    return k;
  endfunction

  function automatic logic [15:0] sat16(input logic [PB:0] v);
    logic [15:0] r;
    r = (v > (PB + 1)'(17'h0FFFF)) ? 16'hFFFF : 16'(v);
    return r;
  endfunction

  // input register
  assign advance     = in_valid && room;
  assign chars.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (chars.ready) begin
      in_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.ready && chars.valid) begin
      in_byte <= chars.source_byte;
    end
  end

  assign used        = byte_position - token_begin;
  assign used_inc    = {1'b0, used} + (PB + 1)'(1);
  assign at_max      = (byte_position == POS_MAX);
  assign match_cont  = at_max ? 4'h0 : kw_step(keyword_match, used, in_byte);
  assign match_first = at_max ? 4'h0 : kw_step(4'hF, '0, in_byte);

  always_comb begin
    mode_next          = mode;
    byte_position_next = byte_position;
    token_begin_next   = token_begin;
    line_count_next    = line_count;
    keyword_match_next = keyword_match;
    consumed = 1'b1;
    a_valid  = 1'b0;
    a_kind   = KIND_EOF;
    a_len    = {1'b0, used};
    b_valid  = 1'b0;
    b_kind   = KIND_EOF;
    b_len    = 16'd0;

    if (advance) begin
      byte_position_next = at_max ? byte_position : byte_position + PB'(1);

      unique case (mode)
        MODE_NUMBER: begin
          if (!is_digit(in_byte)) begin
            a_valid  = 1'b1;
            a_kind   = KIND_NUMBER;
            consumed = 1'b0;
          end
        end
        MODE_IDENT: begin
          if (is_alpha(in_byte) || is_digit(in_byte)) begin
            keyword_match_next = match_cont;
          end else begin
            a_valid  = 1'b1;
            a_kind   = ident_kind(keyword_match, used);
            consumed = 1'b0;
          end
        end
        MODE_LIT_OPEN: begin
          if (in_byte == CHAR_NUL) begin
            a_valid  = 1'b1;
            a_kind   = KIND_ERR_UNTERM;
            consumed = 1'b0;
          end else begin
            mode_next = (in_byte == CHAR_BSLASH) ? MODE_LIT_ESC : MODE_LIT_CLOSE;
          end
        end
        MODE_LIT_ESC: begin
          if (in_byte == CHAR_NUL) begin
            a_valid  = 1'b1;
            a_kind   = KIND_ERR_ESCAPE;
            consumed = 1'b0;
          end else if ((in_byte == CHAR_BSLASH) || (in_byte == "n") ||
                       (in_byte == "t") || (in_byte == "r")) begin
            mode_next = MODE_LIT_CLOSE;
          end else begin
            a_valid   = 1'b1;
            a_kind    = KIND_ERR_ESCAPE;
            a_len     = used_inc;
            mode_next = MODE_IDLE;
          end
        end
        MODE_LIT_CLOSE: begin
          if (in_byte == CHAR_NUL) begin
            a_valid  = 1'b1;
            a_kind   = KIND_ERR_UNTERM;
            consumed = 1'b0;
          end else begin
            a_valid   = 1'b1;
            a_kind    = (in_byte == CHAR_QUOTE) ? KIND_CHARLIT : KIND_ERR_UNTERM;
            a_len     = used_inc;
            mode_next = MODE_IDLE;
          end
        end
        default: begin
          consumed = 1'b0;
        end
      endcase

      // byte not taken by a pending token: scan it from idle
      if (!consumed) begin
        mode_next = MODE_IDLE;
        if (in_byte == CHAR_NUL) begin
          b_valid            = 1'b1;
          b_kind             = KIND_EOF;
          byte_position_next = '0;
          token_begin_next   = '0;
          line_count_next    = 16'd1;
          keyword_match_next = 4'hF;
        end else if (is_space(in_byte)) begin
          if ((in_byte == CHAR_LF) && (line_count != 16'hFFFF)) begin
            line_count_next = line_count + 16'd1;
          end
        end else if (in_byte == CHAR_QUOTE) begin
          token_begin_next = byte_position;
          mode_next        = MODE_LIT_OPEN;
        end else if (is_digit(in_byte)) begin
          token_begin_next = byte_position;
          mode_next        = MODE_NUMBER;
        end else if (is_alpha(in_byte)) begin
          token_begin_next   = byte_position;
          mode_next          = MODE_IDENT;
          keyword_match_next = match_first;
        end else begin
          b_valid = 1'b1;
          b_kind  = punct_kind(in_byte);
          b_len   = 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      byte_position <= '0;
      token_begin   <= '0;
      line_count    <= 16'd1;
      keyword_match <= 4'hF;
    end else begin
      mode          <= mode_next;
      byte_position <= byte_position_next;
      token_begin   <= token_begin_next;
      line_count    <= line_count_next;
      keyword_match <= keyword_match_next;
    end
  end

  always_comb begin
    res_a.token_kind   = a_kind;
    res_a.token_start  = sat16({1'b0, token_begin});
    res_a.token_length = sat16(a_len);
    res_a.line_number  = line_count;
    res_a.last_of_run  = !b_valid;

    res_b.token_kind   = b_kind;
    res_b.token_start  = sat16({1'b0, byte_position});
    res_b.token_length = b_len;
    res_b.line_number  = line_count;
    res_b.last_of_run  = 1'b1;

    push.valid0 = a_valid || b_valid;
    push.valid1 = a_valid && b_valid;
    push.slot0  = a_valid ? res_a : res_b;
    push.slot1  = res_b;
  end

  `CSTOK_ASSERT_NEXT(a_eof_resets, clk, rst, advance && (in_byte == CHAR_NUL), (byte_position == '0) && (line_count == 16'd1) && (mode == MODE_IDLE))
  `CSTOK_ASSERT_SAME(a_begin_not_ahead, clk, rst, 1'b1, token_begin <= byte_position)
  `CSTOK_ASSERT_SAME(a_pair_ends_token, clk, rst, push.valid1, mode != MODE_IDLE)
  `CSTOK_ASSERT_SAME(a_line_nonzero, clk, rst, 1'b1, line_count != 16'd0)

endmodule

/* rtl/cstok_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cstok_fifo
// small result queue, up to two writes and one read per cycle while tokens is ready
// ----------------------------------------------------------------------------
module cstok_fifo (
  input  logic             clk,
  input  logic             rst,
  input  cstok_pkg::push_t push,
  output logic             room,
  cstok_token_if.source    tokens
);
  import cstok_pkg::*;

  result_t              q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QCNT_BITS-1:0] count, count_next;
  logic [QCNT_BITS-1:0] n_push;
  logic                 pop;
  result_t              head;

  assign n_push = QCNT_BITS'(push.valid0) + QCNT_BITS'(push.valid1);
  assign pop    = tokens.valid && tokens.ready;
  assign room   = count <= QCNT_BITS'(QUEUE_DEPTH - 2);
  assign count_next = count + n_push - QCNT_BITS'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push[QPTR_BITS-1:0];
      rd_ptr <= rd_ptr + QPTR_BITS'(pop);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid0) begin
      q[wr_ptr] <= push.slot0;
    end
    if (push.valid1) begin
      q[wr_ptr + QPTR_BITS'(1)] <= push.slot1;
    end
  end

  assign head = q[rd_ptr];

  assign tokens.valid        = count != '0;
  assign tokens.token_kind   = head.token_kind;
  assign tokens.token_start  = head.token_start;
  assign tokens.token_length = head.token_length;
  assign tokens.line_number  = head.line_number;
  assign tokens.last_of_run  = head.last_of_run;

endmodule
